[sv/triangle_area_accumulator_assert.svh]
// assertion macros used by the checker file
`ifndef TRIANGLE_AREA_ACCUMULATOR_ASSERT_SVH
`define TRIANGLE_AREA_ACCUMULATOR_ASSERT_SVH

// condition implies consequence in the same cycle
`define TAA_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("triangle area check failed");

// condition implies consequence in the next cycle
`define TAA_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("triangle area check failed");

`endif

[sv/taa_pkg.sv]
// shared types and constants for the triangle area accumulator
`default_nettype none
package taa_pkg;

    localparam int COORD_BITS       = 16;
    localparam int LENGTH_FRAC_BITS = 8;

    localparam int SUM_W    = 2 * COORD_BITS + 2;
    localparam int SRAD_W   = SUM_W + 2 * LENGTH_FRAC_BITS;
    localparam int LEN_W    = SRAD_W / 2;
    localparam int FAC_W    = LEN_W + 2;
    localparam int PROD_W   = 2 * FAC_W;
    localparam int P_W      = 4 * FAC_W;
    localparam int ROOT_W   = P_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int ITER_W   = $clog2(ROOT_W + 1);
    localparam int AREA_W   = 50;
    localparam int TOTAL_W  = 63;
    localparam int AREA_SH  = 2 * LENGTH_FRAC_BITS + 2 - 16;
    localparam int SHR      = (AREA_SH > 0) ? AREA_SH : 0;
    localparam int SHL      = (AREA_SH < 0) ? -AREA_SH : 0;
    localparam int SCALE_W  = ROOT_W + SHL;

    typedef struct packed {
        logic                          first_triangle;
        logic signed [COORD_BITS-1:0]  v0_x;
        logic signed [COORD_BITS-1:0]  v0_y;
        logic signed [COORD_BITS-1:0]  v0_z;
        logic signed [COORD_BITS-1:0]  v1_x;
        logic signed [COORD_BITS-1:0]  v1_y;
        logic signed [COORD_BITS-1:0]  v1_z;
        logic signed [COORD_BITS-1:0]  v2_x;
        logic signed [COORD_BITS-1:0]  v2_y;
        logic signed [COORD_BITS-1:0]  v2_z;
    } taa_in_t;

    typedef struct packed {
        logic [AREA_W-1:0]  triangle_area;
        logic [TOTAL_W-1:0] total_area;
        logic               degenerate;
        logic               total_saturated;
    } taa_out_t;

    typedef struct packed {
        logic                  first;
        logic [2:0][SUM_W-1:0] sums;
    } taa_job_t;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
    } taa_sqrt_req_t;

endpackage
`default_nettype wire

[sv/triangle_area_accumulator.sv]
// top level of the triangle area accumulator
// Each triangle beat yields one result beat with its area (16 fraction bits), the
// saturating running total and the degenerate and saturation flags. The front end
// accepts a beat per cycle while the queue has room and buffers up to three
// triangles; the back end works on one triangle at a time: three side roots, a sort,
// the Heron multiply, an area root and the accumulate, the multiply and area root
// skipped for a degenerate triangle. All roots use the single shared bit-serial
// square root unit. A new triangle starts in the back end only once the previous
// result beat has been taken.
`default_nettype none
module triangle_area_accumulator
    import taa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  wire taa_in_t  item,
    output logic          result_valid,
    input  wire logic     result_ready,
    output taa_out_t      result
);

    logic     f_valid;
    logic     f_ready;
    taa_job_t f_job;
    logic     q_valid;
    logic     q_pop;
    taa_job_t q_job;

    taa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .job_valid  (f_valid),
        .job_ready  (f_ready),
        .job        (f_job)
    );

    taa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_job)
    );

    taa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_valid),
        .job_pop      (q_pop),
        .job          (q_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire

[sv/taa_front.sv]
// front end: takes triangle beats and forms squared side distances
`default_nettype none
module taa_front
    import taa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  wire taa_in_t  item,
    output logic          job_valid,
    input  wire logic     job_ready,
    output taa_job_t      job
);

    logic                                 valid_reg;
    logic                                 first_reg;
    logic [2:0][2:0][COORD_BITS-1:0]      mag_reg;
    logic [2:0][2:0][COORD_BITS-1:0]      mag_next;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] q
    );
        logic signed [COORD_BITS:0] d;
        d = {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
        abs_diff = d[COORD_BITS] ? COORD_BITS'(-d) : d[COORD_BITS-1:0];
    endfunction

    assign item_ready = !valid_reg || job_ready;
    assign job_valid  = valid_reg;

    always_comb
    begin
        mag_next[0][0] = abs_diff(item.v0_x, item.v1_x);
        mag_next[0][1] = abs_diff(item.v0_y, item.v1_y);
        mag_next[0][2] = abs_diff(item.v0_z, item.v1_z);
        mag_next[1][0] = abs_diff(item.v0_x, item.v2_x);
        mag_next[1][1] = abs_diff(item.v0_y, item.v2_y);
        mag_next[1][2] = abs_diff(item.v0_z, item.v2_z);
        mag_next[2][0] = abs_diff(item.v1_x, item.v2_x);
        mag_next[2][1] = abs_diff(item.v1_y, item.v2_y);
        mag_next[2][2] = abs_diff(item.v1_z, item.v2_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            mag_reg   <= mag_next;
            first_reg <= item.first_triangle;
        end
    end

    // one squarer per side and axis lane, summed per side
    always_comb
    begin
        job.first = first_reg;
        for (int s = 0; s < 3; s++)
        begin
            job.sums[s] = SUM_W'(mag_reg[s][0] * mag_reg[s][0])
                        + SUM_W'(mag_reg[s][1] * mag_reg[s][1])
                        + SUM_W'(mag_reg[s][2] * mag_reg[s][2]);
        end
    end

endmodule
`default_nettype wire

[sv/taa_queue.sv]
// two-entry queue between the front and back ends
`default_nettype none
module taa_queue
    import taa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  wire taa_job_t  push_data,
    output logic           pop_valid,
    input  wire logic      pop,
    output taa_job_t       pop_data
);

    taa_job_t   mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[sv/taa_sqrt.sv]
// bit-serial restoring integer square root, two radicand bits per cycle
`default_nettype none
module taa_sqrt
    import taa_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire taa_sqrt_req_t  req,
    input  wire logic [P_W-1:0] rad,
    output logic                done,
    output logic [ROOT_W-1:0]   root
);

    logic [P_W-1:0]    rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[P_W-1:P_W-2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = (rem_sh >= trial);
    assign done   = done_reg;
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[P_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

endmodule
`default_nettype wire

[sv/taa_back.sv]
// back end: side roots, sort, heron product, area root and running total
`default_nettype none
module taa_back
    import taa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      job_valid,
    output logic           job_pop,
    input  wire taa_job_t  job,
    output logic           result_valid,
    input  wire logic      result_ready,
    output taa_out_t       result
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SIDE = 6'b000010,
        S_SORT = 6'b000100,
        S_MUL  = 6'b001000,
        S_ROOT = 6'b010000,
        S_ACC  = 6'b100000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    taa_job_t               job_reg;
    logic [1:0]             idx_reg;
    logic [2:0][LEN_W-1:0]  len_reg;
    logic [3:0][FAC_W-1:0]  fac_reg;
    logic                   deg_reg;
    logic [2:0]             mcnt_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]      p12_reg;
    logic [PROD_W-1:0]      p34_reg;
    logic [P_W-1:0]         acc_reg;
    logic [P_W-1:0]         acc_next;
    logic [AREA_W-1:0]      area_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   sat_reg;
    logic                   out_valid_reg;
    taa_out_t               out_reg;

    taa_sqrt_req_t          sq_req;
    logic [P_W-1:0]         sq_rad;
    logic                   sq_done;
    logic [ROOT_W-1:0]      sq_root;

    logic [FAC_W-1:0]       mul_a;
    logic [FAC_W-1:0]       mul_b;
    logic [LEN_W-1:0]       na;
    logic [LEN_W-1:0]       nb;
    logic [LEN_W-1:0]       nc;
    logic [LEN_W-1:0]       mx_ab;
    logic [LEN_W-1:0]       mn_ab;
    logic [SCALE_W-1:0]     scaled;
    logic [AREA_W-1:0]      area_clip;
    logic [TOTAL_W-1:0]     base;
    logic [TOTAL_W:0]       sum;

    function automatic logic [P_W-1:0] side_rad(input logic [SUM_W-1:0] s);
        side_rad = {s, (2 * LENGTH_FRAC_BITS)'(0), (P_W - SRAD_W)'(0)};
    endfunction

    taa_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rad   (sq_rad),
        .done  (sq_done),
        .root  (sq_root)
    );

    // sort the three sides
    always_comb
    begin
        mx_ab = (len_reg[0] > len_reg[1]) ? len_reg[0] : len_reg[1];
        mn_ab = (len_reg[0] < len_reg[1]) ? len_reg[0] : len_reg[1];
        na    = (mx_ab > len_reg[2]) ? mx_ab : len_reg[2];
        nc    = (mn_ab < len_reg[2]) ? mn_ab : len_reg[2];
        nb    = LEN_W'(FAC_W'(len_reg[0]) + FAC_W'(len_reg[1]) + FAC_W'(len_reg[2])
              - FAC_W'(na) - FAC_W'(nc));
    end

    // shared multiplier operand select; last four steps build the wide product
    always_comb
    begin
        unique case (mcnt_reg)
            3'd0:    begin mul_a = fac_reg[0];              mul_b = fac_reg[1];              end
            3'd1:    begin mul_a = fac_reg[2];              mul_b = fac_reg[3];              end
            3'd3:    begin mul_a = p12_reg[FAC_W-1:0];      mul_b = p34_reg[FAC_W-1:0];      end
            3'd4:    begin mul_a = p12_reg[FAC_W-1:0];      mul_b = p34_reg[PROD_W-1:FAC_W]; end
            3'd5:    begin mul_a = p12_reg[PROD_W-1:FAC_W]; mul_b = p34_reg[FAC_W-1:0];      end
            3'd6:    begin mul_a = p12_reg[PROD_W-1:FAC_W]; mul_b = p34_reg[PROD_W-1:FAC_W]; end
            default: begin mul_a = '0;                      mul_b = '0;                      end
        endcase
    end

    always_comb
    begin
        unique case (mcnt_reg)
            3'd4:    acc_next = P_W'(prod_reg);
            3'd5:    acc_next = acc_reg + (P_W'(prod_reg) << FAC_W);
            3'd6:    acc_next = acc_reg + (P_W'(prod_reg) << FAC_W);
            3'd7:    acc_next = acc_reg + (P_W'(prod_reg) << PROD_W);
            default: acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        scaled    = (SCALE_W'(sq_root) << SHL) >> SHR;
        area_clip = ((scaled >> AREA_W) != '0) ? '1 : scaled[AREA_W-1:0];
        base      = job_reg.first ? '0 : total_reg;
        sum       = {1'b0, base} + (TOTAL_W + 1)'(area_reg);
    end

    always_comb
    begin
        state_next   = state_reg;
        job_pop      = 1'b0;
        sq_req.start = 1'b0;
        sq_req.iters = ITER_W'(LEN_W);
        sq_rad       = side_rad(job.sums[0]);
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid && !out_valid_reg)
                begin
                    job_pop      = 1'b1;
                    sq_req.start = 1'b1;
                    state_next   = S_SIDE;
                end
            end
            S_SIDE:
            begin
                sq_rad = side_rad(job_reg.sums[idx_reg + 2'd1]);
                if (sq_done)
                begin
                    if (idx_reg == 2'd2)
                    begin
                        state_next = S_SORT;
                    end
                    else
                    begin
                        sq_req.start = 1'b1;
                    end
                end
            end
            S_SORT:
            begin
                state_next = ((FAC_W'(nb) + FAC_W'(nc)) < FAC_W'(na)) ? S_ACC : S_MUL;
            end
            S_MUL:
            begin
                sq_rad       = acc_next;
                sq_req.iters = ITER_W'(ROOT_W);
                if (mcnt_reg == 3'd7)
                begin
                    sq_req.start = 1'b1;
                    state_next   = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (sq_done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 2'd0;
            mcnt_reg      <= 3'd0;
            total_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
            begin
                idx_reg <= 2'd0;
            end
            else if (state_reg == S_SIDE && sq_done)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            mcnt_reg <= (state_reg == S_MUL) ? mcnt_reg + 3'd1 : 3'd0;
            if (result_valid && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_ACC)
            begin
                out_valid_reg <= 1'b1;
                if (sum[TOTAL_W])
                begin
                    total_reg <= '1;
                    sat_reg   <= 1'b1;
                end
                else
                begin
                    total_reg <= sum[TOTAL_W-1:0];
                    sat_reg   <= job_reg.first ? 1'b0 : sat_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
        end
        if (state_reg == S_SIDE && sq_done)
        begin
            len_reg[idx_reg] <= sq_root[LEN_W-1:0];
        end
        if (state_reg == S_SORT)
        begin
            fac_reg[0] <= FAC_W'(na) + FAC_W'(nb) + FAC_W'(nc);
            fac_reg[1] <= FAC_W'(na) + FAC_W'(nb) - FAC_W'(nc);
            fac_reg[2] <= FAC_W'(nb) + FAC_W'(nc) - FAC_W'(na);
            fac_reg[3] <= FAC_W'(nc) + FAC_W'(na) - FAC_W'(nb);
            deg_reg    <= (FAC_W'(nb) + FAC_W'(nc)) < FAC_W'(na);
            area_reg   <= '0;
        end
        prod_reg <= mul_a * mul_b;
        if (mcnt_reg == 3'd1)
        begin
            p12_reg <= prod_reg;
        end
        if (mcnt_reg == 3'd2)
        begin
            p34_reg <= prod_reg;
        end
        acc_reg <= acc_next;
        if (state_reg == S_ROOT && sq_done)
        begin
            area_reg <= area_clip;
        end
        if (state_reg == S_ACC)
        begin
            out_reg.triangle_area   <= area_reg;
            out_reg.degenerate      <= deg_reg;
            out_reg.total_area      <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            out_reg.total_saturated <= sum[TOTAL_W] ? 1'b1
                                     : (job_reg.first ? 1'b0 : sat_reg);
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

[sv/taa_checker.sv]
// port level checks on the triangle area accumulator
`default_nettype none
`include "triangle_area_accumulator_assert.svh"
module taa_checker
    import taa_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     item_valid,
    input wire logic     item_ready,
    input wire taa_in_t  item,
    input wire logic     result_valid,
    input wire logic     result_ready,
    input wire taa_out_t result
);

    `TAA_ASSERT_NEXT(a_item_holds, item_valid && !item_ready, item_valid && $stable(item))
    `TAA_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid && $stable(result))
    `TAA_ASSERT_NOW(a_degenerate_zero, result_valid && result.degenerate, result.triangle_area == '0)
    `TAA_ASSERT_NOW(a_saturated_max, result_valid && result.total_saturated, &result.total_area)
    `TAA_ASSERT_NOW(a_area_in_total, result_valid, {13'd0, result.triangle_area} <= result.total_area)

endmodule

bind triangle_area_accumulator taa_checker u_taa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
`default_nettype wire
